/* sv/subset_sum_counter_core_defines.svh */
// Assertion macros shared by the subset-sum counter checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SUBSET_SUM_COUNTER_CORE_DEFINES_SVH
`define SUBSET_SUM_COUNTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SSC_ASSERT_SAME(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSC_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

/* sv/ssc_pkg.sv */
// Package for the subset-sum counter: sizes, item types, state encoding and
// the lowest-set-bit helper used for the Gray-code subset walk. No dependencies.
package ssc_pkg;

  localparam int MAX_ITEMS = 16;
  localparam int VAL_W     = 30;
  localparam int COUNT_W   = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int VS_AW     = $clog2(MAX_ITEMS);
  localparam int HALF_LO   = MAX_ITEMS / 2;
  localparam int HALF_HI   = MAX_ITEMS - HALF_LO;
  localparam int TBL_AW    = HALF_LO;
  localparam int TBL_DEPTH = 1 << HALF_LO;
  localparam int IDX_W     = HALF_HI + 1;
  localparam int BIT_W     = $clog2(IDX_W);
  localparam int SUM_W     = VAL_W + $clog2(HALF_HI + 1);

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  // Register index is the word-address bit of paddr.
  localparam logic REG_TARGET = 1'b0;

  typedef struct packed {
    logic [VAL_W-1:0] item_value;
    logic             last_item;
  } ssc_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] subset_count;
    logic               overflow_flag;
  } ssc_out_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_H1_REC,
    ST_H1_ADD,
    ST_H2_CHK,
    ST_H2_SCAN,
    ST_H2_LAST,
    ST_H2_NEXT,
    ST_H2_ADD,
    ST_DONE
  } ssc_state_t;

  // Position of the lowest set bit; gives the element that flips between
  // consecutive Gray-code subsets.
  function automatic logic [BIT_W-1:0] lowest_set(input logic [IDX_W-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = IDX_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

/* sv/ssc_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ssc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/subset_sum_counter_core.sv */
// Subset-sum counter top level: value store, half-sum table and the
// meet-in-the-middle walk. Depends on ssc_pkg and ssc_ram.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------
//   input    | in_valid/in_ready  | in_item  (item_value, last_item)
//   result   | out_valid/out_ready| out_result (subset_count, overflow_flag)
//   config   | APB psel/penable   | target_sum at byte address 0
//
// Loading accepts items back to back while in the load state. After the
// last item, with n1 = n/2 and n2 = n - n1, the walk records R first-half
// sums no greater than the target; the single read port of the half-sum
// RAM is then scanned once per second-half subset whose sum does not
// exceed the target. Reset needs no clearing pass. A waiting result does
// not stall loading of the next set.
module subset_sum_counter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ssc_pkg::ssc_in_t              in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ssc_pkg::ssc_out_t             out_result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssc_pkg::PADDR_W-1:0]   paddr,
  input  logic [ssc_pkg::PDATA_W-1:0]   pwdata,
  output logic [ssc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import ssc_pkg::*;

  ssc_state_t state, state_next;

  logic [VAL_W-1:0]   target_sum;
  logic [CNT_W-1:0]   items_held;
  logic               dropped_mark;
  logic [CNT_W-1:0]   n1;
  logic [CNT_W-1:0]   n2;
  logic [IDX_W-1:0]   idx;
  logic [SUM_W-1:0]   acc;
  logic [TBL_AW:0]    rec;
  logic [TBL_AW-1:0]  scan_addr;
  logic               cmp_valid;
  logic [VAL_W-1:0]   key;
  logic [COUNT_W-1:0] total;
  logic               flip_add;

  logic               in_fire;
  logic               out_fire;
  logic               cfg_write;
  logic               store_room;
  logic [CNT_W-1:0]   n_set;
  logic [IDX_W-1:0]   idx_inc;
  logic [IDX_W-1:0]   step_gray;
  logic [BIT_W-1:0]   step_bit;
  logic               h1_end;
  logic               h2_end;
  logic               acc_le_key;
  logic               scan_last;
  logic               done_load;
  logic [SUM_W-1:0]   acc_step;

  logic               vs_we;
  logic [VS_AW-1:0]   vs_waddr;
  logic [VS_AW-1:0]   vs_raddr;
  logic [VAL_W-1:0]   vs_rdata;
  logic               tb_we;
  logic [TBL_AW-1:0]  tb_waddr;
  logic [VAL_W-1:0]   tb_rdata;

  assign in_fire    = in_valid && in_ready;
  assign out_fire   = out_valid && out_ready;
  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign prdata     = (paddr[PADDR_W-1] == REG_TARGET) ? PDATA_W'(target_sum) : '0;

  assign store_room = items_held < CNT_W'(MAX_ITEMS);
  assign n_set      = items_held + CNT_W'(store_room);
  assign idx_inc    = idx + 1'b1;
  assign step_gray  = idx_inc ^ (idx_inc >> 1);
  assign step_bit   = lowest_set(idx_inc);
  assign h1_end     = idx_inc == (IDX_W'(1) << n1);
  assign h2_end     = idx_inc == (IDX_W'(1) << n2);
  assign acc_le_key = acc <= SUM_W'(target_sum);
  assign scan_last  = {1'b0, scan_addr} == (rec - 1'b1);
  assign done_load  = (state == ST_DONE) && (!out_valid || out_ready);
  // Removing an element never underflows: it was added earlier in the walk.
  assign acc_step   = flip_add ? acc + SUM_W'(vs_rdata) : acc - SUM_W'(vs_rdata);

  ssc_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ITEMS)) u_value_store (
    .clk   (clk),
    .we    (vs_we),
    .waddr (vs_waddr),
    .wdata (in_item.item_value),
    .raddr (vs_raddr),
    .rdata (vs_rdata)
  );

  ssc_ram #(.WIDTH(VAL_W), .DEPTH(TBL_DEPTH)) u_half_sums (
    .clk   (clk),
    .we    (tb_we),
    .waddr (tb_waddr),
    .wdata (acc[VAL_W-1:0]),
    .raddr (scan_addr),
    .rdata (tb_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_fire && in_item.last_item) begin
          state_next = ST_H1_REC;
        end
      end
      ST_H1_REC:  state_next = h1_end ? ST_H2_CHK : ST_H1_ADD;
      ST_H1_ADD:  state_next = ST_H1_REC;
      ST_H2_CHK:  state_next = acc_le_key ? ST_H2_SCAN : ST_H2_NEXT;
      ST_H2_SCAN: state_next = scan_last ? ST_H2_LAST : ST_H2_SCAN;
      ST_H2_LAST: state_next = ST_H2_NEXT;
      ST_H2_NEXT: state_next = h2_end ? ST_DONE : ST_H2_ADD;
      ST_H2_ADD:  state_next = ST_H2_CHK;
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_LOAD;
        end
      end
      default:    state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready = state == ST_LOAD;
    vs_we    = in_fire && store_room;
    vs_waddr = items_held[VS_AW-1:0];
    tb_we    = (state == ST_H1_REC) && acc_le_key;
    tb_waddr = rec[TBL_AW-1:0];
    // Second-half elements sit after the first n1 entries of the store.
    if (state == ST_H2_NEXT) begin
      vs_raddr = VS_AW'(n1 + CNT_W'(step_bit));
    end else begin
      vs_raddr = VS_AW'(step_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      target_sum   <= '0;
      items_held   <= '0;
      dropped_mark <= 1'b0;
      out_valid    <= 1'b0;
      cmp_valid    <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= state == ST_H2_SCAN;
      if (cfg_write && paddr[PADDR_W-1] == REG_TARGET) begin
        target_sum <= pwdata[VAL_W-1:0];
      end
      if (in_fire) begin
        if (store_room) begin
          items_held <= items_held + 1'b1;
        end else begin
          dropped_mark <= 1'b1;
        end
      end
      if (done_load) begin
        items_held   <= '0;
        dropped_mark <= 1'b0;
        out_valid    <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_item.last_item) begin
      n1    <= n_set >> 1;
      n2    <= n_set - (n_set >> 1);
      acc   <= '0;
      idx   <= '0;
      rec   <= '0;
      total <= '0;
    end
    unique case (state)
      ST_H1_REC: begin
        if (acc_le_key) begin
          rec <= rec + 1'b1;
        end
        flip_add <= step_gray[step_bit];
        if (h1_end) begin
          acc <= '0;
          idx <= '0;
        end else begin
          idx <= idx_inc;
        end
      end
      ST_H1_ADD, ST_H2_ADD: begin
        acc <= acc_step;
      end
      ST_H2_CHK: begin
        key       <= target_sum - acc[VAL_W-1:0];
        scan_addr <= '0;
      end
      ST_H2_SCAN: begin
        scan_addr <= scan_addr + 1'b1;
      end
      ST_H2_NEXT: begin
        idx      <= idx_inc;
        flip_add <= step_gray[step_bit];
      end
      ST_DONE: begin
        if (done_load) begin
          out_result.subset_count  <= total;
          out_result.overflow_flag <= dropped_mark;
        end
      end
      default: begin
      end
    endcase
    // Table data arrives in the cycle after its scan address.
    if (cmp_valid && tb_rdata == key && total != COUNT_MAX) begin
      total <= total + 1'b1;
    end
  end

endmodule

/* sv/ssc_checker.sv */
// Port-level checker for the subset-sum counter, bound to the top level.
// Depends on ssc_pkg and subset_sum_counter_core_defines.svh.
`include "subset_sum_counter_core_defines.svh"

module ssc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input ssc_pkg::ssc_in_t            in_item,
  input logic                        out_valid,
  input logic                        out_ready,
  input ssc_pkg::ssc_out_t           out_result,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [ssc_pkg::PADDR_W-1:0] paddr,
  input logic [ssc_pkg::PDATA_W-1:0] pwdata,
  input logic [ssc_pkg::PDATA_W-1:0] prdata,
  input logic                        pready
);
  import ssc_pkg::*;

  // A set of n values has at most 2^n subsets.
  localparam logic [COUNT_W-1:0] COUNT_BOUND =
    (MAX_ITEMS >= COUNT_W) ? COUNT_MAX : COUNT_W'(64'd1 << MAX_ITEMS);

  `SSC_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(out_result), "result item changed while stalled")
  `SSC_ASSERT_SAME(a_count_bound, out_valid, out_result.subset_count <= COUNT_BOUND, "subset count above the number of subsets")
  `SSC_ASSERT_NEXT(a_count_starts, in_valid && in_ready && in_item.last_item, !in_ready && !$rose(out_valid), "last item did not start the count")
  `SSC_ASSERT_NEXT(a_target_readback, psel && penable && pwrite && pready && paddr[PADDR_W-1] == REG_TARGET, !(psel && !pwrite && paddr[PADDR_W-1] == REG_TARGET) || prdata == PDATA_W'($past(pwdata[VAL_W-1:0])), "target register reads back wrong")

endmodule

bind subset_sum_counter_core ssc_checker u_ssc_checker (.*);
